@@ rtl/wcs_pkg.sv @@
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types and constants for the per-word sort or reverse block.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int MAX_WORD_LEN = 32;
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);

  localparam logic [7:0] SPACE_CODE = 8'h20;

  localparam logic MODE_SORT    = 1'b0;
  localparam logic MODE_REVERSE = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       word_overflow;
  } out_item_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic       insert;
    logic       pop;
    logic [7:0] new_byte;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/wcs_stream_if.sv @@
// ----------------------------------------------------------------------------
// wcs_in_if / wcs_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface wcs_in_if;
  logic              valid;
  logic              ready;
  wcs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wcs_out_if;
  logic               valid;
  logic               ready;
  wcs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/wcs_cell.sv @@
// ----------------------------------------------------------------------------
// wcs_cell
// One slot of the word row: an arrival-order byte and a sorted-order byte.
// ----------------------------------------------------------------------------
module wcs_cell (
  input  logic                clk,
  input  wcs_pkg::cell_ctrl_t ctrl,
  input  logic                own_valid,
  input  logic                left_le,
  input  logic [7:0]          left_stack,
  input  logic [7:0]          left_sort,
  input  logic [7:0]          right_stack,
  input  logic [7:0]          right_sort,
  output logic [7:0]          stack_q,
  output logic [7:0]          sort_q,
  output logic                le
);

  logic [7:0] stack_next;
  logic [7:0] sort_next;

  // held byte stays in front of the new one
  assign le = own_valid && (sort_q <= ctrl.new_byte);

  always_comb begin
    stack_next = stack_q;
    sort_next  = sort_q;
    if (ctrl.insert) begin
      stack_next = left_stack;
      if (le) begin
        sort_next = sort_q;
      end else if (left_le) begin
        sort_next = ctrl.new_byte;
      end else begin
        sort_next = left_sort;
      end
    end else if (ctrl.pop) begin
      stack_next = right_stack;
      sort_next  = right_sort;
    end
  end

  always_ff @(posedge clk) begin
    stack_q <= stack_next;
    sort_q  <= sort_next;
  end

endmodule

@@ rtl/word_char_sort_reverse.sv @@
// ----------------------------------------------------------------------------
// word_char_sort_reverse
// Per-word byte sort or reverse over a text stream, built on a row of cells.
// ----------------------------------------------------------------------------
// Word bytes enter a row of 32 cells, one a cycle while idle; the row keeps the
// word both in arrival order (a shift stack) and in ascending order (a
// parallel insertion row). A space, or a non-space byte flagged end_of_text,
// starts emission: the row pops one byte a cycle from cell zero while the
// output register can take it, then a trailing space if a space ended the
// word, and no input is accepted meanwhile. A new byte is taken while the last
// result still waits in the output register. Bytes past 32 are dropped and
// flag word_overflow on every result of that word; mode is sampled at emission.
module word_char_sort_reverse (
  input  logic             clk,
  input  logic             rst,
  wcs_in_if.sink           text,
  wcs_out_if.source        result,
  input  logic             mode_we,
  input  logic             mode_wdata
);

  localparam int N = wcs_pkg::MAX_WORD_LEN;
  localparam int W = wcs_pkg::LEN_W;

  wcs_pkg::state_t    state, state_next;
  logic               mode;
  logic [W-1:0]       word_length, word_length_next;
  logic               overflow_seen, overflow_seen_next;
  logic               space_pend;
  logic               out_valid;
  wcs_pkg::out_item_t out_data;

  logic               accept;
  logic               is_space;
  logic               full;
  logic               slot_free;
  logic               emit_fire;
  logic               emit_last;
  logic [7:0]         emit_byte;
  wcs_pkg::cell_ctrl_t ctrl;

  logic [7:0] stack_q [N];
  logic [7:0] sort_q  [N];
  logic       le      [N];

  assign is_space  = text.data.text_byte == wcs_pkg::SPACE_CODE;
  assign full      = word_length == W'(N);
  assign accept    = text.valid && text.ready;
  assign slot_free = !out_valid || result.ready;

  assign ctrl.insert   = accept && !is_space && !full;
  assign ctrl.pop      = emit_fire && (word_length != '0);
  assign ctrl.new_byte = text.data.text_byte;

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    wcs_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .own_valid   (word_length > W'(i)),
      .left_le     ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
      .left_stack  ((i == 0) ? ctrl.new_byte : stack_q[(i == 0) ? 0 : i - 1]),
      .left_sort   ((i == 0) ? 8'h00 : sort_q[(i == 0) ? 0 : i - 1]),
      .right_stack ((i == N - 1) ? 8'h00 : stack_q[(i == N - 1) ? i : i + 1]),
      .right_sort  ((i == N - 1) ? 8'h00 : sort_q[(i == N - 1) ? i : i + 1]),
      .stack_q     (stack_q[i]),
      .sort_q      (sort_q[i]),
      .le          (le[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wcs_pkg::ST_IDLE: begin
        if (accept && (is_space || text.data.end_of_text)) begin
          state_next = wcs_pkg::ST_EMIT;
        end
      end
      wcs_pkg::ST_EMIT: begin
        if (emit_fire && emit_last) begin
          state_next = wcs_pkg::ST_IDLE;
        end
      end
      default: state_next = wcs_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    text.ready = 1'b0;
    emit_fire  = 1'b0;
    unique case (state)
      wcs_pkg::ST_IDLE: text.ready = 1'b1;
      wcs_pkg::ST_EMIT: emit_fire  = slot_free;
      default: begin
        text.ready = 1'b0;
        emit_fire  = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (word_length == '0) begin
      emit_byte = wcs_pkg::SPACE_CODE;
    end else if (mode == wcs_pkg::MODE_REVERSE) begin
      emit_byte = stack_q[0];
    end else begin
      emit_byte = sort_q[0];
    end
    emit_last = (word_length == '0) || ((word_length == W'(1)) && !space_pend);
  end

  always_comb begin
    word_length_next   = word_length;
    overflow_seen_next = overflow_seen;
    if (ctrl.insert) begin
      word_length_next = word_length + W'(1);
    end else if (ctrl.pop) begin
      word_length_next = word_length - W'(1);
    end
    if (accept && !is_space && full) begin
      overflow_seen_next = 1'b1;
    end else if (emit_fire && emit_last) begin
      overflow_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wcs_pkg::ST_IDLE;
      mode          <= wcs_pkg::MODE_SORT;
      word_length   <= '0;
      overflow_seen <= 1'b0;
      space_pend    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      word_length   <= word_length_next;
      overflow_seen <= overflow_seen_next;
      if (mode_we) begin
        mode <= mode_wdata;
      end
      if (accept) begin
        space_pend <= is_space;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.out_byte      <= emit_byte;
      out_data.run_last      <= emit_last;
      out_data.word_overflow <= overflow_seen;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= W'(N))
    else $error("word length beyond capacity");

  a_space_emits: assert property (@(posedge clk) disable iff (rst)
    accept && is_space |=> state == wcs_pkg::ST_EMIT)
    else $error("space did not start emission");

  a_trailing_space: assert property (@(posedge clk) disable iff (rst)
    emit_fire && emit_last && space_pend |=>
      result.valid && result.data.out_byte == wcs_pkg::SPACE_CODE
      && result.data.run_last)
    else $error("word did not close with a space");

  a_no_take_in_emit: assert property (@(posedge clk) disable iff (rst)
    state == wcs_pkg::ST_EMIT |-> !text.ready)
    else $error("input taken during emission");
`endif

endmodule
